/* src/c32hx_pkg.sv */
// Shared constants and helper functions for the CRC-32 over hex text block.
`timescale 1ns / 1ps

package c32hx_pkg;

    localparam int unsigned CRC_WIDTH  = 32;
    localparam int unsigned CHAR_WIDTH = 8;
    localparam int unsigned BYTE_WIDTH = 8;

    // Reflected form of polynomial 0x04C11DB7
    localparam logic [CRC_WIDTH-1:0]  CRC_POLY_REFL     = 32'hEDB8_8320;
    localparam logic [CRC_WIDTH-1:0]  CRC_ALL_ONES      = 32'hFFFF_FFFF;
    localparam logic [CHAR_WIDTH-1:0] ASCII_DIGIT_BASE  = 8'h30;
    // 'A' minus ten, so that nibble 10 lands on 'A'
    localparam logic [CHAR_WIDTH-1:0] ASCII_LETTER_BASE = 8'h37;
    localparam logic [3:0]            NIBBLE_MAX_DIGIT  = 4'd9;

    typedef logic [CRC_WIDTH-1:0]  t_crc;
    typedef logic [CHAR_WIDTH-1:0] t_char;
    typedef logic [BYTE_WIDTH-1:0] t_byte;

    // Map one nibble to its upper-case hex ASCII character
    function automatic t_char hex_char(input logic [3:0] nibble);
        t_char base;
        base = (nibble <= NIBBLE_MAX_DIGIT) ? ASCII_DIGIT_BASE : ASCII_LETTER_BASE;
        return base + {4'd0, nibble};
    endfunction

endpackage

/* src/c32hx_char_step.sv */
// Reflected CRC-32 update over one 8-bit character, LSB first.
`timescale 1ns / 1ps

module c32hx_char_step
    import c32hx_pkg::*;
(
    input  t_crc  i_crc,
    input  t_char i_char,
    output t_crc  o_crc
);

    // Fold the character in, then shift out eight bits
    always_comb begin
        t_crc c;
        c = i_crc ^ {{(CRC_WIDTH-CHAR_WIDTH){1'b0}}, i_char};
        for (int k = 0; k < CHAR_WIDTH; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

/* src/crc32_over_hex_text_top.sv */
// Top level of the CRC-32 over hex text block: input stage, CRC update, result stage.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one raw message byte per transfer
//   in i_data_byte, with i_last_byte high on the final byte of a message.
//   Each byte is expanded to two upper-case hex characters, high nibble first,
//   and both run through a reflected CRC-32 that starts at all ones.
//   Output channel (o_valid / i_stall) carries one transfer per message:
//   o_crc_value is the complemented CRC of the whole hex text.
//   A last byte accepted into the input register moves on to the result
//   register once the result slot is free or its result is being taken.
//   Throughput: one byte per cycle, unless a last byte waits on a held result;
//   the two character updates are unrolled in the logic between the input
//   register and the CRC and result registers.
//   Stall: while i_stall holds a waiting result, non-last bytes keep flowing;
//   a last byte waits in the input register, and o_stall rises only then.
//   Reset (i_rst_n low, synchronous) empties both stages and reloads the CRC
//   register with all ones.
`timescale 1ns / 1ps

module crc32_over_hex_text_top
    import c32hx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_crc_value
);

    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;
    t_crc  r_crc;
    logic  r_out_valid;
    t_crc  r_out_crc;

    logic  n_in_valid;
    t_crc  n_crc;
    logic  n_out_valid;

    t_crc  crc_mid;
    t_crc  crc_done;
    logic  out_free;
    logic  advance;
    logic  in_take;

    // Update the running CRC with both hex characters of the held byte
    c32hx_char_step u_step_hi (
        .i_crc  (r_crc),
        .i_char (hex_char(r_in_byte[7:4])),
        .o_crc  (crc_mid)
    );

    c32hx_char_step u_step_lo (
        .i_crc  (crc_mid),
        .i_char (hex_char(r_in_byte[3:0])),
        .o_crc  (crc_done)
    );

    // Advance the held byte unless it is last and the result slot is occupied and stalled
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = in_take || (r_in_valid && !advance);
        n_crc      = r_crc;
        if (advance) begin
            n_crc = r_in_last ? CRC_ALL_ONES : crc_done;
        end
        n_out_valid = r_out_valid && i_stall;
        if (advance && r_in_last) begin
            n_out_valid = 1'b1;
        end
    end

    // Hold control state and the CRC register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= CRC_ALL_ONES;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_crc       <= n_crc;
        end
    end

    // Capture input payload on each transfer
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Load the complemented CRC when a message ends
    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_crc <= crc_done ^ CRC_ALL_ONES;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the CRC-32 over hex text block.
`timescale 1ns / 1ps

module testbench;
    import c32hx_pkg::*;

    localparam int unsigned RESET_CYCLES   = 8;
    localparam int unsigned MAX_WAIT       = 15;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned HOLD_AFTER     = 25;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned RANDOM_BYTES   = 1700;

    // Expected-CRC store with its own copy of the running register
    class crc_scoreboard;
        t_crc running_crc;
        t_crc pending_crc[$];

        function new();
            running_crc = CRC_ALL_ONES;
        endfunction

        // Upper-case hex digit of one nibble
        function t_char ascii_of_nibble(logic [3:0] nib);
            if (nib < 4'd10)
                return 8'h30 + t_char'(nib);
            return 8'h41 + t_char'(nib) - 8'd10;
        endfunction

        // Fold one character into the register, LSB first
        function t_crc fold_char(t_crc crc, t_char ch);
            t_crc acc;
            acc = crc ^ {24'd0, ch};
            for (int k = 0; k < 8; k++)
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY_REFL) : (acc >> 1);
            return acc;
        endfunction

        // Advance on an accepted input transfer, queue the CRC on a last byte
        function void note_transfer(t_byte data, logic last);
            t_crc crc;
            crc = fold_char(running_crc, ascii_of_nibble(data[7:4]));
            crc = fold_char(crc, ascii_of_nibble(data[3:0]));
            if (last) begin
                pending_crc.push_back(crc ^ CRC_ALL_ONES);
                running_crc = CRC_ALL_ONES;
            end else begin
                running_crc = crc;
            end
        endfunction

        // Compare a result against the oldest queued CRC
        function bit check_result(t_crc got, output t_crc want, output bit orphan);
            want = '0;
            orphan = (pending_crc.size() == 0);
            if (orphan)
                return 1'b0;
            want = pending_crc.pop_front();
            return (got == want);
        endfunction

        function int unsigned pending_count();
            return pending_crc.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_crc_value;

    crc_scoreboard sb;
    int unsigned   error_count   = 0;
    int unsigned   idle_cycles   = 0;
    bit            hold_active   = 1'b0;
    bit            sender_calm   = 1'b0;

    crc32_over_hex_text_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_crc_value (o_crc_value)
    );

    // Free-running clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int unsigned draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Offer one byte, hold it until the block takes the transfer
    task automatic send_byte(input t_byte data, input logic last);
        int unsigned gap;
        gap = draw_wait(sender_calm || hold_active);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_transfer(data, last);
    endtask

    task automatic send_message(input t_byte bytes[$]);
        foreach (bytes[k])
            send_byte(bytes[k], k == bytes.size() - 1);
    endtask

    // Mostly uniform bytes, some on the digit/letter boundaries
    function automatic t_byte pick_byte();
        t_byte edges[13] = '{8'h00, 8'h09, 8'h0A, 8'h0F, 8'h90, 8'h99, 8'h9A,
                             8'hA0, 8'hAF, 8'hF0, 8'hF9, 8'hFA, 8'hFF};
        if ($urandom_range(0, 3) == 0)
            return edges[$urandom_range(0, 12)];
        return t_byte'($urandom_range(0, 255));
    endfunction

    // Receiver: random stall per result, one long hold-off to fill the block
    initial begin : receiver
        int unsigned w;
        int unsigned taken;
        int unsigned calm_left;
        bit          hold_done;
        taken = 0;
        calm_left = 0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_active = 1'b1;
                w = HOLD_CYCLES;
            end else if (calm_left > 0) begin
                calm_left--;
                w = 0;
            end else begin
                if ($urandom_range(0, 9) == 0)
                    calm_left = $urandom_range(5, 30);
                w = draw_wait(1'b0);
            end
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            hold_active = 1'b0;
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken++;
        end
    end

    // Check each result transfer against the oldest expected CRC
    always @(posedge i_clk) begin
        t_crc want;
        bit   orphan;
        if (i_rst_n && o_valid && !i_stall) begin
            if (!sb.check_result(o_crc_value, want, orphan)) begin
                if (orphan)
                    report_mismatch($sformatf("unexpected crc_value %h", o_crc_value));
                else
                    report_mismatch($sformatf("crc_value %h, expected %h",
                                              o_crc_value, want));
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_byte       msg[$];
        int unsigned sent;
        int unsigned len;
        sb = new;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-byte messages on the nibble boundaries
        msg = '{8'h00}; send_message(msg);
        msg = '{8'hFF}; send_message(msg);
        msg = '{8'h09}; send_message(msg);
        msg = '{8'h0A}; send_message(msg);
        msg = '{8'h90}; send_message(msg);
        msg = '{8'hA0}; send_message(msg);
        msg = '{8'h9F}; send_message(msg);
        // Directed: multi-byte messages, register carried across bytes
        msg = '{8'h00, 8'hFF, 8'h0A, 8'h9A, 8'hAF}; send_message(msg);
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_message(msg);
        msg = '{8'h5A, 8'hA5, 8'h3C}; send_message(msg);

        // Random messages, mostly short, some long
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            sender_calm = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                               : $urandom_range(1, 8);
            msg.delete();
            repeat (len) msg.push_back(pick_byte());
            send_message(msg);
            sent += len;
        end
        i_valid <= 1'b0;

        // Drain, then allow the pipeline latency to settle
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
